FILE: hw/rtl/phts_pkg.sv
// shared types and constants for the peak-hold thermometer session timer
// no dependencies; used by every module of the block
package phts_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_OFFSET     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SESSION_MINUTES = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_START     = 2'd2;

  // input command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_WAKE = 1'b1;

  // display invert codes
  localparam logic [1:0] INV_NONE    = 2'd0;
  localparam logic [1:0] INV_NORMAL  = 2'd1;
  localparam logic [1:0] INV_REVERSE = 2'd2;

  // tenth counter points of interest
  localparam logic [3:0] TENTH_RESET     = 4'd3;
  localparam logic [3:0] TENTH_SECOND    = 4'd10;
  localparam logic [3:0] TENTH_COLON_OFF = 4'd7;
  localparam logic [3:0] TENTH_BUZZ_OFF  = 4'd3;

  localparam logic [5:0] SEC_LAST = 6'd59;

  localparam logic [3:0] SESSION_MINUTES_RESET = 4'd5;
  localparam logic [3:0] BLINK_START_RESET     = 4'd3;

  typedef struct packed {
    logic signed [7:0] temp_offset;
    logic [3:0]        session_minutes;
    logic [3:0]        blink_start_minute;
  } cfg_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
    logic [3:0] tenths;
  } digits_t;

  typedef struct packed {
    logic       second_event;
    logic [3:0] tens_digit;
    logic [3:0] ones_digit;
    logic [3:0] tenths_digit;
    logic [3:0] minute_count;
    logic [5:0] second_count;
    logic       colon_on;
    logic       buzzer_on;
    logic [1:0] invert_cmd;
    logic       asleep;
  } result_t;

endpackage

FILE: hw/rtl/peak_hold_thermometer_session_timer.sv
// top level of the peak-hold thermometer session timer: input stage,
// configuration registers and result register around phts_core
// depends on phts_pkg, phts_core, phts_digits
//
//  port group   direction  handshake            payload
//  input        in         in_valid / in_stall  cmd, sample
//  result       out        out_valid/ out_stall second_event .. asleep
//  config       in         cfg_wr_en            cfg_index, cfg_data
//
// each transaction passes the input register and then the result register,
// and a new transaction can enter every cycle while the result is not stalled
// rst resets the session state and the config registers and clears both valid flags
// a stalled result holds the core; the input stage still takes one more
// transaction while the result register waits
module peak_hold_thermometer_session_timer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                cmd,
  input  logic signed [11:0]                  sample,
  input  logic                                cfg_wr_en,
  input  logic [phts_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [phts_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                second_event,
  output logic [3:0]                          tens_digit,
  output logic [3:0]                          ones_digit,
  output logic [3:0]                          tenths_digit,
  output logic [3:0]                          minute_count,
  output logic [5:0]                          second_count,
  output logic                                colon_on,
  output logic                                buzzer_on,
  output logic [1:0]                          invert_cmd,
  output logic                                asleep
);

  phts_pkg::cfg_t     cfg;
  phts_pkg::result_t  res, res_r;

  logic               in_full;
  logic               cmd_r;
  logic signed [11:0] sample_r;
  logic               go;
  logic               in_accept;

  assign go        = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !go;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_offset        <= '0;
      cfg.session_minutes    <= phts_pkg::SESSION_MINUTES_RESET;
      cfg.blink_start_minute <= phts_pkg::BLINK_START_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        phts_pkg::CFG_TEMP_OFFSET:     cfg.temp_offset        <= cfg_data;
        phts_pkg::CFG_SESSION_MINUTES: cfg.session_minutes    <= cfg_data[3:0];
        phts_pkg::CFG_BLINK_START:     cfg.blink_start_minute <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_accept) begin
      in_full <= 1'b1;
    end else if (go) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r    <= cmd;
      sample_r <= sample;
    end
  end

  phts_core u_core (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .cmd    (cmd_r),
    .sample (sample_r),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= res;
    end
  end

  assign second_event = res_r.second_event;
  assign tens_digit   = res_r.tens_digit;
  assign ones_digit   = res_r.ones_digit;
  assign tenths_digit = res_r.tenths_digit;
  assign minute_count = res_r.minute_count;
  assign second_count = res_r.second_count;
  assign colon_on     = res_r.colon_on;
  assign buzzer_on    = res_r.buzzer_on;
  assign invert_cmd   = res_r.invert_cmd;
  assign asleep       = res_r.asleep;

endmodule

FILE: hw/rtl/phts_digits.sv
// splits the peak temperature into tens, ones and tenths display digits
// depends on phts_pkg
module phts_digits (
  input  logic signed [12:0] peak,
  output phts_pkg::digits_t  digits
);

  logic [11:0] ipart;
  logic [3:0]  frac;
  logic [23:0] q_prod;
  logic [5:0]  q100;
  logic [11:0] rem_full;
  logic [6:0]  rem;
  logic [13:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  ones_full;
  logic [7:0]  tenths_prod;

  // integer degrees come from the masked 12 bits of the sign-extended peak
  assign ipart = {{3{peak[12]}}, peak[12:4]};
  assign frac  = peak[3:0];

  // ipart / 100 as multiply by 1311 / 2^17, exact for 12-bit values
  assign q_prod   = 24'(ipart) * 24'd1311;
  assign q100     = q_prod[22:17];
  assign rem_full = ipart - 12'(q100) * 12'd100;
  assign rem      = rem_full[6:0];

  // rem / 10 as multiply by 103 / 2^10, exact below 179
  assign tens_prod = 14'(rem) * 14'd103;
  assign tens      = tens_prod[13:10];
  assign ones_full = rem - 7'(tens) * 7'd10;

  assign tenths_prod = 8'(frac) * 8'd10;

  assign digits.tens   = tens;
  assign digits.ones   = ones_full[3:0];
  assign digits.tenths = tenths_prod[7:4];

endmodule

FILE: hw/rtl/phts_core.sv
// session state registers and the per-item update of the thermometer timer
// depends on phts_pkg and phts_digits
module phts_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic              cmd,
  input  logic signed [11:0] sample,
  input  phts_pkg::cfg_t    cfg,
  output phts_pkg::result_t res
);

  logic [3:0]         tenth_count, tenth_count_next;
  logic [5:0]         sec_reg, sec_reg_next;
  logic [3:0]         min_reg, min_reg_next;
  logic signed [12:0] peak_temp, peak_temp_next;
  logic               buzzer_reg, buzzer_reg_next;
  logic               colon_reg, colon_reg_next;
  logic               sleep_reg, sleep_reg_next;
  phts_pkg::digits_t  digit_hold, digit_hold_next;

  logic signed [12:0] adj;
  logic signed [12:0] step_peak;
  phts_pkg::digits_t  step_digits;
  logic [3:0]         tick_count;
  logic [3:0]         min_inc;
  logic               event_flag;
  logic [1:0]         invert;

  assign adj = 13'(sample) + 13'(cfg.temp_offset);
  // minute 0 follows the sample, later minutes hold the maximum
  assign step_peak = ((min_reg == 4'd0) || (peak_temp < adj)) ? adj : peak_temp;
  assign tick_count = tenth_count + 4'd1;
  assign min_inc    = min_reg + 4'd1;

  phts_digits u_digits (
    .peak   (step_peak),
    .digits (step_digits)
  );

  always_comb begin
    tenth_count_next = tenth_count;
    sec_reg_next     = sec_reg;
    min_reg_next     = min_reg;
    peak_temp_next   = peak_temp;
    buzzer_reg_next  = buzzer_reg;
    colon_reg_next   = colon_reg;
    sleep_reg_next   = sleep_reg;
    digit_hold_next  = digit_hold;
    event_flag       = 1'b0;
    invert           = phts_pkg::INV_NONE;

    if (cmd == phts_pkg::CMD_WAKE) begin
      sleep_reg_next   = 1'b0;
      peak_temp_next   = '0;
      tenth_count_next = phts_pkg::TENTH_RESET;
    end else if (!sleep_reg) begin
      tenth_count_next = tick_count;
      if (tick_count == phts_pkg::TENTH_SECOND) begin
        tenth_count_next = '0;
        event_flag       = 1'b1;
        if ((sec_reg == 6'd0) || (sec_reg < 6'(min_reg))) begin
          buzzer_reg_next = 1'b1;
        end
        peak_temp_next  = step_peak;
        digit_hold_next = step_digits;
        colon_reg_next  = 1'b1;
        if (sec_reg == phts_pkg::SEC_LAST) begin
          sec_reg_next = '0;
          min_reg_next = min_inc;
          if (min_inc == cfg.session_minutes) begin
            sleep_reg_next = 1'b1;
            min_reg_next   = '0;
          end
        end else begin
          sec_reg_next = sec_reg + 6'd1;
        end
        if (min_reg_next >= cfg.blink_start_minute) begin
          invert = sec_reg_next[0] ? phts_pkg::INV_REVERSE : phts_pkg::INV_NORMAL;
        end
      end else if (tick_count == phts_pkg::TENTH_COLON_OFF) begin
        colon_reg_next = 1'b0;
      end
      if (tick_count == phts_pkg::TENTH_BUZZ_OFF) begin
        buzzer_reg_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tenth_count <= phts_pkg::TENTH_RESET;
      sec_reg     <= '0;
      min_reg     <= '0;
      peak_temp   <= '0;
      buzzer_reg  <= 1'b1;
      colon_reg   <= 1'b0;
      sleep_reg   <= 1'b0;
      digit_hold  <= '0;
    end else if (go) begin
      tenth_count <= tenth_count_next;
      sec_reg     <= sec_reg_next;
      min_reg     <= min_reg_next;
      peak_temp   <= peak_temp_next;
      buzzer_reg  <= buzzer_reg_next;
      colon_reg   <= colon_reg_next;
      sleep_reg   <= sleep_reg_next;
      digit_hold  <= digit_hold_next;
    end
  end

  always_comb begin
    res.second_event = event_flag;
    res.tens_digit   = digit_hold_next.tens;
    res.ones_digit   = digit_hold_next.ones;
    res.tenths_digit = digit_hold_next.tenths;
    res.minute_count = min_reg_next;
    res.second_count = sec_reg_next;
    res.colon_on     = colon_reg_next;
    res.buzzer_on    = buzzer_reg_next;
    res.invert_cmd   = invert;
    res.asleep       = sleep_reg_next;
  end

endmodule

FILE: verif/session_scoreboard_pkg.sv
// scoreboard for the peak-hold thermometer session timer testbench
// predicts each result from accepted transactions and checks the block's results; needs phts_pkg
`timescale 1ns / 100ps
package session_scoreboard_pkg;

  class session_scoreboard;
    phts_pkg::result_t  expected_q[$];
    int                 errors;
    int                 checked;
    // configuration copy
    logic signed [7:0]  temp_offset;
    logic [3:0]         session_minutes;
    logic [3:0]         blink_start;
    // session state
    logic [3:0]         tenth_count;
    logic [5:0]         seconds;
    logic [3:0]         minutes;
    logic signed [12:0] peak;
    logic               buzzer;
    logic               colon;
    logic               sleeping;
    phts_pkg::digits_t  digits;

    function new();
      errors          = 0;
      checked         = 0;
      temp_offset     = '0;
      session_minutes = phts_pkg::SESSION_MINUTES_RESET;
      blink_start     = phts_pkg::BLINK_START_RESET;
      tenth_count     = phts_pkg::TENTH_RESET;
      seconds         = '0;
      minutes         = '0;
      peak            = '0;
      buzzer          = 1'b1;
      colon           = 1'b0;
      sleeping        = 1'b0;
      digits          = '0;
    endfunction

    function void write_reg(logic [phts_pkg::CFG_INDEX_W-1:0] index,
                            logic [phts_pkg::CFG_DATA_W-1:0] data);
      case (index)
        phts_pkg::CFG_TEMP_OFFSET:     temp_offset = data;
        phts_pkg::CFG_SESSION_MINUTES: session_minutes = data[3:0];
        phts_pkg::CFG_BLINK_START:     blink_start = data[3:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic cmd, logic signed [11:0] sample);
      phts_pkg::result_t  r;
      logic               fired;
      logic [1:0]         invert;
      logic signed [12:0] adj;
      logic [15:0]        wide;
      int unsigned        whole;
      int unsigned        frac;
      fired  = 1'b0;
      invert = phts_pkg::INV_NONE;
      if (cmd == phts_pkg::CMD_WAKE) begin
        // sample is dropped, peak and tenth count are reset, digits, seconds and minutes are kept
        sleeping    = 1'b0;
        peak        = '0;
        tenth_count = phts_pkg::TENTH_RESET;
      end else if (!sleeping) begin
        tenth_count = tenth_count + 4'd1;
        if (tenth_count == phts_pkg::TENTH_SECOND) begin
          tenth_count = '0;
          fired       = 1'b1;
          if (seconds == '0 || seconds < {2'b00, minutes}) begin
            buzzer = 1'b1;
          end
          adj = $signed({sample[11], sample}) + $signed({{5{temp_offset[7]}}, temp_offset});
          // during minute zero the peak just follows the sample
          if (minutes == '0 || peak < adj) begin
            peak = adj;
          end
          // a negative peak shows its masked 12-bit integer part
          wide          = {{3{peak[12]}}, peak};
          whole         = wide[15:4] % 100;
          frac          = peak[3:0];
          digits.tens   = 4'(whole / 10);
          digits.ones   = 4'(whole % 10);
          digits.tenths = 4'(frac * 10 / 16);
          colon         = 1'b1;
          if (seconds == phts_pkg::SEC_LAST) begin
            seconds = '0;
            minutes = minutes + 4'd1;
            // a session of zero minutes needs the 4-bit wrap to match
            if (minutes == session_minutes) begin
              sleeping = 1'b1;
              minutes  = '0;
            end
          end else begin
            seconds = seconds + 6'd1;
          end
          if (minutes >= blink_start) begin
            invert = seconds[0] ? phts_pkg::INV_REVERSE : phts_pkg::INV_NORMAL;
          end
        end else if (tenth_count == phts_pkg::TENTH_COLON_OFF) begin
          colon = 1'b0;
        end
        if (tenth_count == phts_pkg::TENTH_BUZZ_OFF) begin
          buzzer = 1'b0;
        end
      end
      r.second_event = fired;
      r.tens_digit   = digits.tens;
      r.ones_digit   = digits.ones;
      r.tenths_digit = digits.tenths;
      r.minute_count = minutes;
      r.second_count = seconds;
      r.colon_on     = colon;
      r.buzzer_on    = buzzer;
      r.invert_cmd   = invert;
      r.asleep       = sleeping;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 200) begin
        $display("mismatch: %s", msg);
      end
    endtask

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
        report($sformatf("result %0d %s: got %0d, expected %0d", checked, name, got, want));
      end
    endtask

    task check_result(phts_pkg::result_t got);
      phts_pkg::result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with no transaction pending", checked));
      end else begin
        want = expected_q.pop_front();
        check_field("second_event", got.second_event, want.second_event);
        check_field("tens_digit", got.tens_digit, want.tens_digit);
        check_field("ones_digit", got.ones_digit, want.ones_digit);
        check_field("tenths_digit", got.tenths_digit, want.tenths_digit);
        check_field("minute_count", got.minute_count, want.minute_count);
        check_field("second_count", got.second_count, want.second_count);
        check_field("colon_on", got.colon_on, want.colon_on);
        check_field("buzzer_on", got.buzzer_on, want.buzzer_on);
        check_field("invert_cmd", got.invert_cmd, want.invert_cmd);
        check_field("asleep", got.asleep, want.asleep);
      end
      checked++;
    endtask
  endclass

endpackage

FILE: verif/testbench.sv
// top of the testbench for the peak-hold thermometer session timer
// drives transactions and register writes, checks results; needs phts_pkg, session_scoreboard_pkg
`timescale 1ns / 100ps
module testbench;

  // index with no register behind it
  localparam logic [phts_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic                             cmd = phts_pkg::CMD_TICK;
  logic signed [11:0]               sample = '0;
  logic                             cfg_wr_en = 1'b0;
  logic [phts_pkg::CFG_INDEX_W-1:0] cfg_index = phts_pkg::CFG_TEMP_OFFSET;
  logic [phts_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             second_event;
  logic [3:0]                       tens_digit;
  logic [3:0]                       ones_digit;
  logic [3:0]                       tenths_digit;
  logic [3:0]                       minute_count;
  logic [5:0]                       second_count;
  logic                             colon_on;
  logic                             buzzer_on;
  logic [1:0]                       invert_cmd;
  logic                             asleep;

  session_scoreboard_pkg::session_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  peak_hold_thermometer_session_timer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .sample       (sample),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .second_event (second_event),
    .tens_digit   (tens_digit),
    .ones_digit   (ones_digit),
    .tenths_digit (tenths_digit),
    .minute_count (minute_count),
    .second_count (second_count),
    .colon_on     (colon_on),
    .buzzer_on    (buzzer_on),
    .invert_cmd   (invert_cmd),
    .asleep       (asleep)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin : receive
    phts_pkg::result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.second_event = second_event;
      got.tens_digit   = tens_digit;
      got.ones_digit   = ones_digit;
      got.tenths_digit = tenths_digit;
      got.minute_count = minute_count;
      got.second_count = second_count;
      got.colon_on     = colon_on;
      got.buzzer_on    = buzzer_on;
      got.invert_cmd   = invert_cmd;
      got.asleep       = asleep;
      sb.check_result(got);
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic signed [11:0] rand_sample();
    case ($urandom_range(7))
      0: return 12'sh800;
      1: return 12'sh7ff;
      2: return 12'($urandom_range(32)) - 12'd16;
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic send(logic c, logic signed [11:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    sample   <= s;
    do @(posedge clk); while (in_stall);
    sb.note_input(c, s);
  endtask

  task automatic write_reg(logic [phts_pkg::CFG_INDEX_W-1:0] index,
                           logic [phts_pkg::CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(index, data);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // upper data bits are don't-care for the 4-bit registers
  task automatic configure(logic signed [7:0] offset, logic [3:0] session, logic [3:0] blink);
    write_reg(phts_pkg::CFG_TEMP_OFFSET, offset);
    write_reg(phts_pkg::CFG_SESSION_MINUTES, {4'($urandom), session});
    write_reg(phts_pkg::CFG_BLINK_START, {4'($urandom), blink});
  endtask

  task automatic drain(int extra);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // mostly ticks with random samples; a sleeping block gets a few dropped ticks, then a wake
  task automatic run_phase(int count, int send_pct, int recv_pct);
    int done;
    done          = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (done < count) begin
      if (sb.sleeping) begin
        if ($urandom_range(3) == 0) begin
          send(phts_pkg::CMD_WAKE, rand_sample());
          done++;
        end else begin
          send(phts_pkg::CMD_TICK, rand_sample());
        end
      end else begin
        send(($urandom_range(49) == 0) ? phts_pkg::CMD_WAKE : phts_pkg::CMD_TICK,
             rand_sample());
        done++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 22;
    recv_idle_pct = 65;
    // seventh tick runs the first second step, -1 gives a negative peak
    repeat (7) send(phts_pkg::CMD_TICK, -12'sd1);
    repeat (10) send(phts_pkg::CMD_TICK, 12'sh7ff);
    // wake while awake, its sample must be ignored
    send(phts_pkg::CMD_WAKE, 12'sh800);
    repeat (7) send(phts_pkg::CMD_TICK, 12'sh800);
    drain(4);

    configure(8'sd127, 4'd1, 4'd0);
    write_reg(CFG_UNUSED, 8'($urandom));
    run_phase(650, 22, 65);
    drain(4);

    configure(-8'sd128, 4'd2, 4'd15);
    run_phase(150, 65, 22);
    drain(4);

    configure(8'($urandom), 4'd15, 4'd1);
    run_phase(140, 65, 22);
    drain(4);

    configure(8'($urandom), 4'd3, 4'd2);
    run_phase(140, 0, 0);
    drain(4);

    // zero session minutes: a minute boundary passes without sleep
    configure(8'sd0, 4'd0, 4'd15);
    run_phase(650, 0, 0);
    drain(10);

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
